// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the per-barcode flag statistics RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/pbafs_pkg.sv =====
// Package for the per-barcode alignment flag statistics block: field widths,
// command codes, SAM flag bits, counter ids, controller/datapath structs.
package pbafs_pkg;

   localparam int NUM_BARCODES_DEF = 1024;
   localparam int COUNTER_BITS_DEF = 32;
   localparam int NUM_COUNTERS     = 13;

   localparam int IDX_W     = 10;
   localparam int MAPQ_W    = 8;
   localparam int FLAG_W    = 12;
   localparam int SEL_W     = 4;
   localparam int VALUE_W   = 32;
   localparam int REQ_DATA_W = 40;

   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // SAM flag bit positions
   localparam int FB_PAIRED        = 0;
   localparam int FB_PROPER        = 1;
   localparam int FB_UNMAPPED      = 2;
   localparam int FB_MATE_UNMAPPED = 3;
   localparam int FB_READ1         = 6;
   localparam int FB_READ2         = 7;
   localparam int FB_SECONDARY     = 8;
   localparam int FB_DUP           = 10;
   localparam int FB_SUPPL         = 11;

   // counter ids within a row
   localparam int CNT_PRIMARY      = 0;
   localparam int CNT_SECONDARY    = 1;
   localparam int CNT_SUPPL        = 2;
   localparam int CNT_DUP          = 3;
   localparam int CNT_PRIMARY_DUP  = 4;
   localparam int CNT_MAPPED       = 5;
   localparam int CNT_PRIMARY_MAP  = 6;
   localparam int CNT_PAIRED       = 7;
   localparam int CNT_READ1        = 8;
   localparam int CNT_READ2        = 9;
   localparam int CNT_PROPER       = 10;
   localparam int CNT_BOTH_MAPPED  = 11;
   localparam int CNT_SINGLETON    = 12;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic update;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic rsp_busy;
   } ctl_stat_type;

   function automatic logic [NUM_COUNTERS-1:0] flag_hits(input logic [FLAG_W-1:0] f);
      logic paired;
      logic mapped;
      logic mate_mapped;
      logic primary;
      logic [NUM_COUNTERS-1:0] h;
      paired      = f[FB_PAIRED];
      mapped      = ~f[FB_UNMAPPED];
      mate_mapped = ~f[FB_MATE_UNMAPPED];
      primary     = ~f[FB_SECONDARY] & ~f[FB_SUPPL];
      h = '0;
      h[CNT_PRIMARY]     = primary;
      h[CNT_SECONDARY]   = f[FB_SECONDARY];
      h[CNT_SUPPL]       = f[FB_SUPPL];
      h[CNT_DUP]         = f[FB_DUP];
      h[CNT_PRIMARY_DUP] = f[FB_DUP] & primary;
      h[CNT_MAPPED]      = mapped;
      h[CNT_PRIMARY_MAP] = mapped & primary;
      h[CNT_PAIRED]      = paired;
      h[CNT_READ1]       = paired & f[FB_READ1];
      h[CNT_READ2]       = paired & f[FB_READ2];
      h[CNT_PROPER]      = paired & f[FB_PROPER] & mapped;
      h[CNT_BOTH_MAPPED] = paired & mapped & mate_mapped;
      h[CNT_SINGLETON]   = paired & mapped & ~mate_mapped;
      return h;
   endfunction

endpackage

// ===== rtl/pbafs_ctrl.sv =====
// Controller for the flag statistics block: clearing pass, accept, execute.
// Depends on pbafs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pbafs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pbafs_pkg::ctl_stat_type stat,
   output pbafs_pkg::ctl_cmd_type  cmd
);
   import pbafs_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.capture  = accept;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.is_read) begin
               if (!stat.rsp_busy) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC)
   `ASSERT_NEXT(a_clear_holds, clock, reset, (state_ff == ST_CLEAR) && !stat.clear_last,
                state_ff == ST_CLEAR)
   `ASSERT_IMPLY(a_no_cmd_clash, clock, reset, cmd.clear_wr, !cmd.update && !cmd.load_rsp)

endmodule

// ===== rtl/pbafs_dp.sv =====
// Datapath for the flag statistics block: counter row memory, clear sweep,
// saturating row update, read select and result register. Uses pbafs_pkg.
`include "assert_macros.svh"
module pbafs_dp #(
   parameter int NUM_BARCODES = pbafs_pkg::NUM_BARCODES_DEF,
   parameter int COUNTER_BITS = pbafs_pkg::COUNTER_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pbafs_pkg::MAPQ_W-1:0]    csr_wr_data,
   input  logic                            req_cmd,
   input  logic [pbafs_pkg::IDX_W-1:0]     req_index,
   input  logic                            req_known,
   input  logic [pbafs_pkg::MAPQ_W-1:0]    req_mapq,
   input  logic [pbafs_pkg::FLAG_W-1:0]    req_flag,
   input  logic [pbafs_pkg::SEL_W-1:0]     req_select,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pbafs_pkg::VALUE_W-1:0]   rsp_value,
   input  pbafs_pkg::ctl_cmd_type          cmd,
   output pbafs_pkg::ctl_stat_type         stat
);
   import pbafs_pkg::*;

   localparam int ROW_W  = (NUM_BARCODES > 1) ? $clog2(NUM_BARCODES) : 1;
   localparam int LINE_W = NUM_COUNTERS * COUNTER_BITS;

   logic [LINE_W-1:0] mem [NUM_BARCODES];
   logic [LINE_W-1:0] rdata_ff;
   logic [LINE_W-1:0] wdata;
   logic [ROW_W-1:0]  waddr;
   logic              mem_we;

   logic [ROW_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [MAPQ_W-1:0] qual_floor_ff, qual_floor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [VALUE_W-1:0] sel_value;

   logic              cap_cmd_ff;
   logic [ROW_W-1:0]  cap_row_ff;
   logic              cap_known_ff;
   logic [MAPQ_W-1:0] cap_mapq_ff;
   logic [FLAG_W-1:0] cap_flag_ff;
   logic [SEL_W-1:0]  cap_sel_ff;
   logic              cap_range_ff;

   logic [NUM_COUNTERS-1:0] hits;
   logic              count_ok;

   // item capture and row read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_cmd_ff   <= req_cmd;
         cap_row_ff   <= ROW_W'(req_index);
         cap_known_ff <= req_known;
         cap_mapq_ff  <= req_mapq;
         cap_flag_ff  <= req_flag;
         cap_sel_ff   <= req_select;
         cap_range_ff <= (32'(req_index) < 32'(NUM_BARCODES));
         rdata_ff     <= mem[ROW_W'(req_index)];
      end
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
   end

   assign hits     = flag_hits(cap_flag_ff);
   assign count_ok = cap_known_ff & (cap_mapq_ff >= qual_floor_ff) & cap_range_ff;

   always_comb begin
      logic [COUNTER_BITS-1:0] c;
      c     = '0;
      wdata = '0;
      if (!cmd.clear_wr) begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            c = rdata_ff[k*COUNTER_BITS +: COUNTER_BITS];
            wdata[k*COUNTER_BITS +: COUNTER_BITS] = (hits[k] && !(&c)) ? c + 1'b1 : c;
         end
      end
   end

   assign waddr  = cmd.clear_wr ? clr_cnt_ff : cap_row_ff;
   assign mem_we = cmd.clear_wr | (cmd.update & (cap_cmd_ff == CMD_COUNT) & count_ok);

   always_comb begin
      sel_value = '0;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         if (cap_sel_ff == SEL_W'(k)) begin
            sel_value = VALUE_W'(rdata_ff[k*COUNTER_BITS +: COUNTER_BITS]);
         end
      end
      if (!cap_range_ff) sel_value = '0;
   end

   always_comb begin
      clr_cnt_in    = cmd.clear_wr ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      qual_floor_in = csr_wr_en ? csr_wr_data : qual_floor_ff;
      rsp_valid_in  = cmd.load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         qual_floor_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_cnt_ff    <= clr_cnt_in;
         qual_floor_ff <= qual_floor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) rsp_value_ff <= sel_value;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign stat.clear_last = (clr_cnt_ff == ROW_W'(NUM_BARCODES - 1));
   assign stat.is_read    = (cap_cmd_ff == CMD_READ);
   assign stat.rsp_busy   = rsp_valid_ff & ~rsp_tready;

   `ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_rsp, rsp_valid_ff)
   `ASSERT_IMPLY(a_write_is_count, clock, reset, mem_we && !cmd.clear_wr,
                 (cap_cmd_ff == CMD_COUNT) && cap_range_ff)
   `ASSERT_IMPLY(a_load_is_read, clock, reset, cmd.load_rsp, cap_cmd_ff == CMD_READ)

endmodule

// ===== rtl/per_barcode_alignment_flag_stats_top.sv =====
// Per-barcode alignment flag statistics, top level.
// A read's row is registered at acceptance; the selected counter is then loaded
// into the result register, held off while the previous result still waits on rsp_tready.
// One transaction at a time: row read, then row update or select.
// After reset a clearing pass writes one counter row per cycle, all rows, with
// req_tready low; the mapping-quality floor resets to 0. Uses pbafs_pkg.
module per_barcode_alignment_flag_stats_top #(
   parameter int NUM_BARCODES = pbafs_pkg::NUM_BARCODES_DEF,
   parameter int COUNTER_BITS = pbafs_pkg::COUNTER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pbafs_pkg::MAPQ_W-1:0]        csr_wr_data,   // mapping-quality floor
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // barcode_index[9:0] barcode_known[10] map_quality[18:11] sam_flag[30:19]
   // counter_select[34:31], zero pad [39:35]
   input  logic [pbafs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,     // cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pbafs_pkg::VALUE_W-1:0]       rsp_tdata      // counter_value
);
   import pbafs_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   pbafs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pbafs_dp #(
      .NUM_BARCODES (NUM_BARCODES),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_cmd     (req_tuser),
      .req_index   (req_tdata[9:0]),
      .req_known   (req_tdata[10]),
      .req_mapq    (req_tdata[18:11]),
      .req_flag    (req_tdata[30:19]),
      .req_select  (req_tdata[34:31]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_value   (rsp_tdata),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
